// ===== hdl/ibmfc_pkg.sv =====
// Shared constants and a helper function for the IBM/IEEE single float converter.
`timescale 1ns / 1ps

package ibmfc_pkg;

    // Conversion direction
    localparam logic MODE_IBM_TO_IEEE = 1'b0;
    localparam logic MODE_IEEE_TO_IBM = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_EXACT     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Format constants
    localparam logic [9:0]  ExpBiasAdj  = 10'd130;
    localparam logic [6:0]  IbmBias     = 7'd64;
    localparam logic [9:0]  IeeeExpMax  = 10'd255;
    localparam logic [30:0] IeeeInfBits = 31'h7F80_0000;

    // Leading-zero count of a 24-bit fraction; zero input gives 0
    function automatic logic [4:0] lzc24(input logic [23:0] f);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && f[i]) begin
                n     = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/ibm_ieee_single_float_converter.sv =====
// Top level: three-stage pipelined IBM hex float <-> IEEE-754 single converter.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------
//   input   | in_valid  | in_stall  | mode, word_in
//   output  | out_valid | out_stall | word_out, status
//
// One word per cycle is sustained while out_stall is low. Stage 1 counts leading
// zeros, stage 2 normalizes the fraction and forms both exponents, stage 3
// range-checks and packs the result. Reset clears only the stage valid bits.
// A stall fills bubbles first, then holds every stage; in_stall rises only when
// all three stages are full.
`timescale 1ns / 1ps

module ibm_ieee_single_float_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] word_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] word_out,
    output logic [1:0]  status
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic load1, load2, load3;

    // Stage 1
    logic        s1_mode_reg;
    logic [31:0] s1_word_reg;
    logic [4:0]  s1_lz_reg;

    // Stage 2
    logic              s2_mode_reg, s2_mode_next;
    logic              s2_sign_reg, s2_sign_next;
    logic              s2_fzero_reg, s2_fzero_next;
    logic [22:0]       s2_frac_reg, s2_frac_next;
    logic signed [9:0] s2_exp_reg, s2_exp_next;
    logic [31:0]       s2_ibm_reg, s2_ibm_next;

    // Stage 3
    logic [31:0] word_out_reg, word_out_next;
    logic [1:0]  status_reg, status_next;

    logic [23:0] s1_norm;
    logic [8:0]  s1_t;
    logic [6:0]  s1_ie;
    logic [2:0]  s1_sh;
    logic [23:0] s1_ifr;

    // Advance a stage when it is empty or its contents move on
    assign load3    = !s3_valid_reg || !out_stall;
    assign load2    = !s2_valid_reg || load3;
    assign load1    = !s1_valid_reg || load2;
    assign in_stall = !load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                s1_valid_reg <= in_valid;
            if (load2)
                s2_valid_reg <= s1_valid_reg;
            if (load3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_mode_reg <= mode;
            s1_word_reg <= word_in;
            s1_lz_reg   <= ibmfc_pkg::lzc24(word_in[23:0]);
        end
    end

    // Stage 2: normalize IBM fraction, build IBM result for the other direction
    always_comb
    begin
        s1_norm = s1_word_reg[23:0] << s1_lz_reg;
        s1_t    = {1'b0, s1_word_reg[30:23]} + 9'(ibmfc_pkg::ExpBiasAdj);
        s1_ie   = s1_t[8:2] + 7'd1;
        s1_sh   = 3'd4 - {1'b0, s1_t[1:0]};
        s1_ifr  = {1'b1, s1_word_reg[22:0]} >> s1_sh;

        s2_mode_next  = s1_mode_reg;
        s2_sign_next  = s1_word_reg[31];
        s2_fzero_next = (s1_word_reg[23:0] == 24'd0);
        s2_frac_next  = s1_norm[22:0];
        s2_exp_next   = $signed({1'b0, s1_word_reg[30:24], 2'b00})
                        - $signed(ibmfc_pkg::ExpBiasAdj)
                        - $signed({5'd0, s1_lz_reg});
        if (s1_word_reg[30:23] == 8'd0)
            s2_ibm_next = {s1_word_reg[31], ibmfc_pkg::IbmBias, 24'd0};
        else
            s2_ibm_next = {s1_word_reg[31], s1_ie, s1_ifr};
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_mode_reg  <= s2_mode_next;
            s2_sign_reg  <= s2_sign_next;
            s2_fzero_reg <= s2_fzero_next;
            s2_frac_reg  <= s2_frac_next;
            s2_exp_reg   <= s2_exp_next;
            s2_ibm_reg   <= s2_ibm_next;
        end
    end

    // Stage 3: range check and pack
    always_comb
    begin
        status_next   = ibmfc_pkg::ST_EXACT;
        word_out_next = s2_ibm_reg;
        if (s2_mode_reg == ibmfc_pkg::MODE_IBM_TO_IEEE)
        begin
            priority if (s2_fzero_reg)
                word_out_next = {s2_sign_reg, 31'd0};
            else if (s2_exp_reg >= $signed(ibmfc_pkg::IeeeExpMax))
            begin
                word_out_next = {s2_sign_reg, ibmfc_pkg::IeeeInfBits};
                status_next   = ibmfc_pkg::ST_OVERFLOW;
            end
            else if (s2_exp_reg <= 10'sd0)
            begin
                word_out_next = {s2_sign_reg, 31'd0};
                status_next   = ibmfc_pkg::ST_UNDERFLOW;
            end
            else
                word_out_next = {s2_sign_reg, s2_exp_reg[7:0], s2_frac_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            word_out_reg <= word_out_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign word_out  = word_out_reg;
    assign status    = status_reg;

endmodule

// ===== hdl/ibmfc_checker.sv =====
// Port-level checker for the converter and its bind to the top level.
`timescale 1ns / 1ps

module ibmfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] word_out,
    input logic [1:0]  status
);

    // A held result keeps its bits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(word_out) && $stable(status))
        else $error("result changed while stalled");

    // Hold the input only when a result is waiting on a stalled output
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the pipeline can advance");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ibmfc_pkg::ST_OVERFLOW
        |-> word_out[30:0] == ibmfc_pkg::IeeeInfBits)
        else $error("overflow result is not infinity");

    a_unf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ibmfc_pkg::ST_UNDERFLOW |-> word_out[30:0] == 31'd0)
        else $error("underflow result is not zero");

endmodule

bind ibm_ieee_single_float_converter ibmfc_checker u_ibmfc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_out  (word_out),
    .status    (status)
);

// ===== tb/ibmfc_result_checker.sv =====
// Checker for the float converter: predicts each transfer in and compares each transfer out.
`timescale 1ns / 1ps

module ibmfc_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [31:0] word_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] word_out,
    input  logic [1:0]  status,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          overflow_seen,
    output int          underflow_seen
);

    typedef struct packed {
        logic        mode;
        logic [31:0] word_in;
        logic [31:0] word_out;
        logic [1:0]  status;
    } conversion_t;

    conversion_t expected_conversions[$];

    function automatic conversion_t convert_word(input logic m, input logic [31:0] w);
        conversion_t r;
        logic [23:0] frac;
        logic [23:0] mant;
        logic [6:0]  ibm_exp;
        int          ieee_exp;
        int          biased;
        r.mode    = m;
        r.word_in = w;
        r.status  = ibmfc_pkg::ST_EXACT;
        if (m == ibmfc_pkg::MODE_IBM_TO_IEEE)
        begin
            frac     = w[23:0];
            ieee_exp = int'(w[30:24]) * 4 - int'(ibmfc_pkg::ExpBiasAdj);
            if (frac == 24'd0)
                r.word_out = {w[31], 31'd0};
            else
            begin
                // normalize to a leading one at bit 23, one binary place per shift
                while (!frac[23])
                begin
                    frac     = frac << 1;
                    ieee_exp = ieee_exp - 1;
                end
                if (ieee_exp >= int'(ibmfc_pkg::IeeeExpMax))
                begin
                    r.word_out = {w[31], ibmfc_pkg::IeeeInfBits};
                    r.status   = ibmfc_pkg::ST_OVERFLOW;
                end
                else if (ieee_exp <= 0)
                begin
                    r.word_out = {w[31], 31'd0};
                    r.status   = ibmfc_pkg::ST_UNDERFLOW;
                end
                else
                    r.word_out = {w[31], ieee_exp[7:0], frac[22:0]};
            end
        end
        else
        begin
            if (w[30:23] == 8'd0)
                r.word_out = {w[31], ibmfc_pkg::IbmBias, 24'd0};
            else
            begin
                // truncate the mantissa so the binary exponent lands on a hex digit
                biased     = int'(w[30:23]) + int'(ibmfc_pkg::ExpBiasAdj);
                ibm_exp    = 7'(biased / 4 + 1);
                mant       = {1'b1, w[22:0]} >> (4 - biased % 4);
                r.word_out = {w[31], ibm_exp, mant};
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        conversion_t expected;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_conversions.push_back(convert_word(mode, word_in));
            if (out_valid && !out_stall)
            begin
                if (expected_conversions.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word_out=%h status=%0d",
                                 $realtime, word_out, status);
                end
                else
                begin
                    expected = expected_conversions.pop_front();
                    checked  = checked + 1;
                    if (status == ibmfc_pkg::ST_OVERFLOW)
                        overflow_seen = overflow_seen + 1;
                    if (status == ibmfc_pkg::ST_UNDERFLOW)
                        underflow_seen = underflow_seen + 1;
                    if (word_out !== expected.word_out || status !== expected.status)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mode=%0d in=%h: exp %h/%0d, got %h/%0d",
                                     $realtime, expected.mode, expected.word_in,
                                     expected.word_out, expected.status, word_out, status);
                    end
                end
            end
            outstanding = expected_conversions.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives the float converter and reports the verdict from its checker.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int CHUNK_ITEMS      = 48;
    localparam int CHUNKS           = 11;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        mode      = ibmfc_pkg::MODE_IBM_TO_IEEE;
    logic [31:0] word_in   = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] word_out;
    logic [1:0]  status;

    int mismatches;
    int outstanding;
    int checked;
    int overflow_seen;
    int underflow_seen;

    int gap_max   = 0;
    int stall_max = 0;
    bit long_hold = 1'b0;
    int ibm_words = 0;
    int ieee_words = 0;
    int cycle_count = 0;

    ibm_ieee_single_float_converter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .word_in   (word_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_out  (word_out),
        .status    (status)
    );

    ibmfc_result_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .word_in        (word_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_out       (word_out),
        .status         (status),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .overflow_seen  (overflow_seen),
        .underflow_seen (underflow_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_word(input logic m, input logic [31:0] w);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        word_in  <= w;
        if (m == ibmfc_pkg::MODE_IBM_TO_IEEE)
            ibm_words = ibm_words + 1;
        else
            ieee_words = ieee_words + 1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic pick_word(output logic m, output logic [31:0] w);
        int          kind;
        logic [6:0]  ibm_exp;
        logic [7:0]  ieee_exp;
        logic [23:0] frac;
        kind = $urandom_range(9, 0);
        w    = $urandom;
        m    = 1'($urandom_range(1, 0));
        case (kind)
            4, 5:
            begin
                // IBM words near the ends of the IEEE exponent range
                m = ibmfc_pkg::MODE_IBM_TO_IEEE;
                if ($urandom_range(1, 0))
                    ibm_exp = 7'($urandom_range(40, 0));
                else
                    ibm_exp = 7'($urandom_range(127, 90));
                frac = w[23:0] >> $urandom_range(23, 0);
                w    = {w[31], ibm_exp, frac};
            end
            6:
            begin
                m = ibmfc_pkg::MODE_IBM_TO_IEEE;
                w[23:0] = $urandom_range(1, 0) ? 24'd0 : (24'd1 << $urandom_range(23, 0));
            end
            7, 8:
            begin
                m = ibmfc_pkg::MODE_IEEE_TO_IBM;
                case ($urandom_range(3, 0))
                    0: ieee_exp = 8'd0;
                    1: ieee_exp = 8'd255;
                    2: ieee_exp = 8'($urandom_range(4, 1));
                    default: ieee_exp = 8'($urandom_range(254, 250));
                endcase
                w[30:23] = ieee_exp;
            end
            default:
            begin
            end
        endcase
    endtask

    // Sender
    initial
    begin
        logic        m;
        logic [31:0] w;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_max   = 3;
        stall_max = 3;
        // IBM to IEEE: signed zeros, ones, saturation and flush at both range edges
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h0000_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h8000_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h7F00_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h4110_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'hC110_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h7FFF_FFFF);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'hFFFF_FFFF);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h0000_0001);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h80FF_FFFF);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h60FF_FFFF);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h6110_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h610F_FFFF);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'h2140_0000);
        send_word(ibmfc_pkg::MODE_IBM_TO_IEEE, 32'hA120_0000);
        // IEEE to IBM: zeros, denormals, ones, infinities, NaN, extreme normals
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h0000_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h807F_FFFF);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h0000_0001);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h3F80_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'hBF80_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h7F80_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'hFF80_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h7FFF_FFFF);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h0080_0000);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h7F7F_FFFF);
        send_word(ibmfc_pkg::MODE_IEEE_TO_IBM, 32'h4000_0000);

        in_valid <= 1'b0;
        wait_drained();

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            case ($urandom_range(2, 0))
                0: gap_max = 0;
                1: gap_max = 4;
                default: gap_max = 18;
            endcase
            case ($urandom_range(2, 0))
                0: stall_max = 0;
                1: stall_max = 4;
                default: stall_max = 18;
            endcase
            if (chunk == 3)
            begin
                // back the pipeline up against a blocked output
                gap_max   = 0;
                long_hold = 1'b1;
            end
            if (chunk == 6)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            for (int i = 0; i < CHUNK_ITEMS; i++)
            begin
                pick_word(m, w);
                send_word(m, w);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge clk);

        $display("Ran %0d words: %0d IBM to IEEE, %0d IEEE to IBM, mixed idle and stall",
                 ibm_words + ieee_words, ibm_words, ieee_words);
        $display("%0d results checked, %0d saturated, %0d flushed to zero, %0d mismatches",
                 checked, overflow_seen, underflow_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver
    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                n = 0;
            end
            else
                n = $urandom_range(stall_max, 0);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            forever
            begin
                @(posedge clk);
                if (out_valid)
                    break;
            end
            @(negedge clk);
        end
    end

endmodule

// ===== ibm_ieee_single_float_converter.f =====
hdl/ibmfc_pkg.sv
hdl/ibm_ieee_single_float_converter.sv
hdl/ibmfc_checker.sv
tb/ibmfc_result_checker.sv
tb/tb.sv
